/* rtl/wdist_pkg.sv */
// Shared types, constants and command/status bundles for the histogram distance unit.
package wdist_pkg;

	localparam int DATA_W       = 32;
	localparam int MASS_W       = 48;
	localparam int TOTAL_W      = 56;
	localparam int PROB_W       = 33;
	localparam int ACC_W        = 48;
	localparam int DIV_STEPS    = 32;
	localparam int DEF_MAX_BINS = 256;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_PROB_FLOOR = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_WRITE,
		ST_CHECK,
		ST_READ,
		ST_DIVA,
		ST_WAITA,
		ST_DIVB,
		ST_WAITB,
		ST_POST,
		ST_PROD,
		ST_ACC,
		ST_NEXT,
		ST_OUT
	} wdist_state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic mul;
		logic write;
		logic start_pass;
		logic pass2;
		logic div_start;
		logic div_b;
		logic take_a;
		logic take_b;
		logic post;
		logic prod;
		logic acc;
		logic idx_inc;
		logic idx_clr;
		logic res_empty;
		logic res_load;
		logic clr_pair;
	} wdist_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;
		logic empty;
		logic idx_last;
		logic div_done;
		logic floor_on;
	} wdist_status_t;

endpackage

/* rtl/wdist_div.sv */
// Restoring fractional divider: floor(num * 2^32 / den), capped at 2^32 when num >= den.
module wdist_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wdist_pkg::TOTAL_W-1:0]   num,
	input  logic [wdist_pkg::TOTAL_W-1:0]   den,
	output logic                            done,
	output logic [wdist_pkg::PROB_W-1:0]    quo
);
	import wdist_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic [TOTAL_W:0]    rem_q;
	logic [TOTAL_W-1:0]  den_q;
	logic [DATA_W-1:0]   quo_q;
	logic                cap_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [TOTAL_W:0]    rem_sh;
	logic                take;

	// One shift-compare-subtract step
	assign rem_sh = {rem_q[TOTAL_W-1:0], 1'b0};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			cnt_q <= '0;
			if (num >= den) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
			cap_q <= num >= den;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[DATA_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = {cap_q, quo_q};

	a_cap_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && quo[PROB_W-1] |-> quo[DATA_W-1:0] == '0)
		else $error("capped quotient has low bits set");
	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy_q || !done_q)
		else $error("divider busy and done together");
	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q)
		else $error("divider reports done while stepping");

endmodule

/* rtl/wdist_ctrl.sv */
// Sequencer for loading, normalization passes, cumulative pass and result delivery.
module wdist_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	output logic                      result_valid,
	input  logic                      result_stall,
	input  wdist_pkg::wdist_status_t  st,
	output wdist_pkg::wdist_cmd_t     cmd
);
	import wdist_pkg::*;

	wdist_state_t state_q, state_d;
	logic         pass2_q, pass2_d;
	logic         fin;

	// Last pass either when no floor is set or on the renormalization pass
	assign fin = pass2_q || !st.floor_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass2_q <= pass2_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		pass2_d      = pass2_q;
		cmd          = '0;
		cmd.pass2    = pass2_q;
		item_stall   = 1'b1;
		result_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = st.last ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				if (st.empty) begin
					cmd.res_empty = 1'b1;
					state_d       = ST_OUT;
				end else begin
					cmd.start_pass = 1'b1;
					pass2_d        = 1'b0;
					state_d        = ST_READ;
				end
			end
			ST_READ: state_d = ST_DIVA;
			ST_DIVA: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAITA;
			end
			ST_WAITA: begin
				if (st.div_done) begin
					cmd.take_a = 1'b1;
					state_d    = ST_DIVB;
				end
			end
			ST_DIVB: begin
				cmd.div_start = 1'b1;
				cmd.div_b     = 1'b1;
				state_d       = ST_WAITB;
			end
			ST_WAITB: begin
				cmd.div_b = 1'b1;
				if (st.div_done) begin
					cmd.take_b = 1'b1;
					state_d    = ST_POST;
				end
			end
			ST_POST: begin
				cmd.post = 1'b1;
				state_d  = fin ? ST_PROD : ST_NEXT;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (st.idx_last) begin
					if (fin) begin
						cmd.res_load = 1'b1;
						state_d      = ST_OUT;
					end else begin
						cmd.idx_clr = 1'b1;
						pass2_d     = 1'b1;
						state_d     = ST_READ;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_OUT: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					cmd.clr_pair = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/wdist_dp.sv */
// Datapath: bin stores, mass products, totals, shared divider, CDF and distance accumulation.
module wdist_dp #(
	parameter int MAX_BINS = wdist_pkg::DEF_MAX_BINS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wdist_pkg::wdist_cmd_t            cmd,
	output wdist_pkg::wdist_status_t         st,
	input  logic signed [wdist_pkg::DATA_W-1:0] range_low,
	input  logic signed [wdist_pkg::DATA_W-1:0] range_high,
	input  logic [wdist_pkg::DATA_W-1:0]     probability_floor,
	input  logic signed [wdist_pkg::DATA_W-1:0] count_first,
	input  logic signed [wdist_pkg::DATA_W-1:0] count_second,
	input  logic [wdist_pkg::DATA_W-1:0]     bin_span,
	input  logic signed [wdist_pkg::DATA_W-1:0] bin_middle,
	input  logic                             final_bin,
	output logic [wdist_pkg::DATA_W-1:0]     distance,
	output logic                             distance_valid
);
	import wdist_pkg::*;

	localparam int IDX_W = $clog2(MAX_BINS);
	localparam int CNT_W = $clog2(MAX_BINS + 1);
	localparam int SUM_W = PROB_W + IDX_W;

	// Bin stores
	logic [MASS_W-1:0] mass_a_mem [MAX_BINS];
	logic [MASS_W-1:0] mass_b_mem [MAX_BINS];
	logic [DATA_W-1:0] wid_mem    [MAX_BINS];
	logic [PROB_W-1:0] prob_a_mem [MAX_BINS];
	logic [PROB_W-1:0] prob_b_mem [MAX_BINS];

	logic [MASS_W-1:0] mass_a_rd_q, mass_b_rd_q;
	logic [DATA_W-1:0] wid_rd_q;
	logic [PROB_W-1:0] prob_a_rd_q, prob_b_rd_q;

	// Captured word
	logic signed [DATA_W-1:0] cf_q, cs_q, mid_q;
	logic [DATA_W-1:0]        span_q;
	logic                     last_q;
	logic [2*DATA_W-1:0]      mprod_a_q, mprod_b_q;
	logic                     keep_q;

	logic [CNT_W-1:0]   kept_q;
	logic [IDX_W-1:0]   idx_q;
	logic [TOTAL_W-1:0] tot_a_q, tot_b_q;
	logic [SUM_W-1:0]   ren_a_q, ren_b_q;
	logic [SUM_W-1:0]   cdf_a_q, cdf_b_q;
	logic [PROB_W-1:0]  qa_q, qb_q;
	logic [2*DATA_W:0]  cprod_q;
	logic [ACC_W-1:0]   acc_q;
	logic [DATA_W-1:0]  distance_q;
	logic               dvalid_q;

	logic [DATA_W-1:0]  ua, ub;
	logic               keep_c;
	logic [MASS_W-1:0]  mass_a, mass_b;
	logic [TOTAL_W:0]   tsum_a, tsum_b;
	logic [TOTAL_W-1:0] div_num, div_den;
	logic               div_done;
	logic [PROB_W-1:0]  div_quo;
	logic [PROB_W-1:0]  fl_a, fl_b;
	logic [SUM_W-1:0]   diff;
	logic [PROB_W-1:0]  diff_cap;

	// Clamp, range selection and masses
	assign ua     = cf_q[DATA_W-1] ? '0 : cf_q;
	assign ub     = cs_q[DATA_W-1] ? '0 : cs_q;
	assign keep_c = !((range_low < range_high) && (mid_q < range_low || mid_q > range_high));
	assign mass_a = mprod_a_q[2*DATA_W-1:16];
	assign mass_b = mprod_b_q[2*DATA_W-1:16];
	assign tsum_a = {1'b0, tot_a_q} + (TOTAL_W+1)'(mass_a);
	assign tsum_b = {1'b0, tot_b_q} + (TOTAL_W+1)'(mass_b);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cf_q   <= count_first;
			cs_q   <= count_second;
			span_q <= bin_span;
			mid_q  <= bin_middle;
			last_q <= final_bin;
		end
		if (cmd.mul) begin
			mprod_a_q <= ua * span_q;
			mprod_b_q <= ub * span_q;
			keep_q    <= keep_c;
		end
	end

	// Store writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.write && keep_q && kept_q < CNT_W'(MAX_BINS)) begin
			mass_a_mem[kept_q[IDX_W-1:0]] <= mass_a;
			mass_b_mem[kept_q[IDX_W-1:0]] <= mass_b;
			wid_mem[kept_q[IDX_W-1:0]]    <= span_q;
		end
		if (cmd.post && !cmd.pass2) begin
			prob_a_mem[idx_q] <= fl_a;
			prob_b_mem[idx_q] <= fl_b;
		end
		mass_a_rd_q <= mass_a_mem[idx_q];
		mass_b_rd_q <= mass_b_mem[idx_q];
		wid_rd_q    <= wid_mem[idx_q];
		prob_a_rd_q <= prob_a_mem[idx_q];
		prob_b_rd_q <= prob_b_mem[idx_q];
	end

	// Bin count and saturating totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q  <= '0;
			tot_a_q <= '0;
			tot_b_q <= '0;
		end else if (cmd.clr_pair) begin
			kept_q  <= '0;
			tot_a_q <= '0;
			tot_b_q <= '0;
		end else if (cmd.write && keep_q && kept_q < CNT_W'(MAX_BINS)) begin
			kept_q  <= kept_q + CNT_W'(1);
			tot_a_q <= tsum_a[TOTAL_W] ? '1 : tsum_a[TOTAL_W-1:0];
			tot_b_q <= tsum_b[TOTAL_W] ? '1 : tsum_b[TOTAL_W-1:0];
		end
	end

	// Divider operand select: mass over total, or floored probability over its sum
	always_comb begin
		if (cmd.pass2) begin
			div_num = TOTAL_W'(cmd.div_b ? prob_b_rd_q : prob_a_rd_q);
			div_den = TOTAL_W'(cmd.div_b ? ren_b_q : ren_a_q);
		end else begin
			div_num = TOTAL_W'(cmd.div_b ? mass_b_rd_q : mass_a_rd_q);
			div_den = cmd.div_b ? tot_b_q : tot_a_q;
		end
	end

	wdist_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Floor and CDF difference
	assign fl_a     = (qa_q < PROB_W'(probability_floor)) ? PROB_W'(probability_floor) : qa_q;
	assign fl_b     = (qb_q < PROB_W'(probability_floor)) ? PROB_W'(probability_floor) : qb_q;
	assign diff     = (cdf_a_q >= cdf_b_q) ? cdf_a_q - cdf_b_q : cdf_b_q - cdf_a_q;
	assign diff_cap = (diff > SUM_W'(64'h1_0000_0000)) ? PROB_W'(64'h1_0000_0000)
	                                                   : diff[PROB_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.take_a) qa_q <= div_quo;
		if (cmd.take_b) qb_q <= div_quo;
		if (cmd.prod)   cprod_q <= diff_cap * wid_rd_q;
	end

	// Pass state: index, renormalization sums, CDFs, accumulator, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ren_a_q  <= '0;
			ren_b_q  <= '0;
			cdf_a_q  <= '0;
			cdf_b_q  <= '0;
			acc_q    <= '0;
			dvalid_q <= 1'b0;
		end else begin
			if (cmd.start_pass) begin
				idx_q   <= '0;
				ren_a_q <= '0;
				ren_b_q <= '0;
				cdf_a_q <= '0;
				cdf_b_q <= '0;
				acc_q   <= '0;
			end else if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.post) begin
				if (cmd.pass2 || probability_floor == '0) begin
					cdf_a_q <= cdf_a_q + SUM_W'(qa_q);
					cdf_b_q <= cdf_b_q + SUM_W'(qb_q);
				end else begin
					ren_a_q <= ren_a_q + SUM_W'(fl_a);
					ren_b_q <= ren_b_q + SUM_W'(fl_b);
				end
			end
			if (cmd.acc) acc_q <= acc_q + ACC_W'(cprod_q[2*DATA_W:DATA_W]);
			if (cmd.res_empty) dvalid_q <= 1'b0;
			else if (cmd.res_load) dvalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_empty) distance_q <= '0;
		else if (cmd.res_load) distance_q <= (|acc_q[ACC_W-1:DATA_W]) ? '1 : acc_q[DATA_W-1:0];
	end

	// Status
	assign st.last     = last_q;
	assign st.empty    = kept_q == '0 || tot_a_q == '0 || tot_b_q == '0;
	assign st.idx_last = CNT_W'(idx_q) == kept_q - CNT_W'(1);
	assign st.div_done = div_done;
	assign st.floor_on = probability_floor != '0;

	assign distance       = distance_q;
	assign distance_valid = dvalid_q;

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= CNT_W'(MAX_BINS))
		else $error("bin count beyond store depth");
	a_pair_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_pair |=> kept_q == '0 && tot_a_q == '0 && tot_b_q == '0)
		else $error("pair state not cleared");
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_empty |=> distance_q == '0 && !dvalid_q)
		else $error("empty result not zero");

endmodule

/* rtl/histogram_wasserstein_distance_unit.sv */
// Top level: configuration registers and the controller/datapath pair.
// Each word carries one bin of both histograms; item_stall holds off the next word until the
// current one is written. After the final bin the unit revisits every kept bin: per bin two
// 32-step divisions on one shared restoring divider plus a floor or CDF update, with a second
// pass over the kept bins when probability_floor is nonzero (flooring, then renormalization).
// One result word follows each final bin; distance_valid is low with distance zero when no bin
// was kept or a histogram sum was zero. Registers sit at byte addresses 0, 4 and 8.
module histogram_wasserstein_distance_unit #(
	parameter int MAX_BINS = wdist_pkg::DEF_MAX_BINS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [wdist_pkg::DATA_W-1:0]      pwdata,
	output logic [wdist_pkg::DATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic signed [wdist_pkg::DATA_W-1:0] count_first,
	input  logic signed [wdist_pkg::DATA_W-1:0] count_second,
	input  logic [wdist_pkg::DATA_W-1:0]      bin_span,
	input  logic signed [wdist_pkg::DATA_W-1:0] bin_middle,
	input  logic                              final_bin,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [wdist_pkg::DATA_W-1:0]      distance,
	output logic                              distance_valid
);
	import wdist_pkg::*;

	logic signed [DATA_W-1:0] range_low_q, range_high_q;
	logic [DATA_W-1:0]        floor_q;
	logic                     wr_en;
	wdist_cmd_t               cmd;
	wdist_status_t            st;

	// Register writes
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '0;
			floor_q      <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_RANGE_LOW:  range_low_q  <= pwdata;
				REG_RANGE_HIGH: range_high_q <= pwdata;
				REG_PROB_FLOOR: floor_q      <= pwdata;
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_RANGE_LOW:  prdata = range_low_q;
			REG_RANGE_HIGH: prdata = range_high_q;
			REG_PROB_FLOOR: prdata = floor_q;
			default:        prdata = '0;
		endcase
	end

	wdist_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.st           (st),
		.cmd          (cmd)
	);

	wdist_dp #(
		.MAX_BINS (MAX_BINS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.range_low         (range_low_q),
		.range_high        (range_high_q),
		.probability_floor (floor_q),
		.count_first       (count_first),
		.count_second      (count_second),
		.bin_span          (bin_span),
		.bin_middle        (bin_middle),
		.final_bin         (final_bin),
		.distance          (distance),
		.distance_valid    (distance_valid)
	);

endmodule
